// ===== hdl/tvt_pkg.sv =====
// ----------------------------------------------------------------------------
// tvt_pkg
// Shared types, codes and constants of the triangle vertex transform.
// ----------------------------------------------------------------------------
package tvt_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned SAT_W     = 68;
  localparam int unsigned TRIG_BITS = 30;
  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned NUM_VERT  = 3;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // constant divider: 4 quotient bits per cycle
  localparam int unsigned DIV_W      = 40;
  localparam int unsigned DIV_REM_W  = 16;
  localparam int unsigned DIV_DIGITS = 4;
  localparam int unsigned DIV_ITERS  = DIV_W / DIV_DIGITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_ITERS + 1);

  localparam logic [14:0] DIV_BY_3   = 15'd3;
  localparam logic [14:0] ANGLE_FULL = 15'd23040;
  localparam logic [14:0] ANGLE_DIV  = 15'd45;
  localparam int unsigned PHASE_SHIFT = 23;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_SCALE     = 3'd2,
    OP_ROTATE    = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    DV_CEN = 2'd0,
    DV_DEP = 2'd1,
    DV_MOD = 2'd2,
    DV_PH  = 2'd3
  } div_dst_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_LATCH, DP_LOAD, DP_TRANS, DP_CEN, DP_DEP, DP_MOD, DP_PH,
    DP_COR, DP_PIV_ANCHOR, DP_ROT_PRE, DP_ROT, DP_ROT_POST, DP_SCL, DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic [1:0]  vi;
    logic [1:0]  ax;
    logic [2:0]  step;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       anchor_en;
    logic       div_done;
    logic       cor_done;
    logic       out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [1:0]         vertex_slot;
    logic signed [31:0] op_x;
    logic signed [31:0] op_y;
    logic signed [31:0] op_z;
    logic               use_anchor;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         out_slot;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] centroid_depth;
    logic               last_vertex;
  } out_word_t;

  function automatic logic signed [31:0] angle_step(input logic [4:0] idx);
    logic signed [31:0] r;
    unique case (idx)
      5'd0:  r = 32'sd536870912;
      5'd1:  r = 32'sd316933406;
      5'd2:  r = 32'sd167458907;
      5'd3:  r = 32'sd85004756;
      5'd4:  r = 32'sd42667331;
      5'd5:  r = 32'sd21354465;
      5'd6:  r = 32'sd10680862;
      5'd7:  r = 32'sd5340245;
      5'd8:  r = 32'sd2670163;
      5'd9:  r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41721;
      5'd15: r = 32'sd20860;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2607;
      5'd19: r = 32'sd1303;
      5'd20: r = 32'sd651;
      5'd21: r = 32'sd325;
      5'd22: r = 32'sd162;
      5'd23: r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -68'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hdl/tvt_if.sv =====
// ----------------------------------------------------------------------------
// tvt_if
// Valid/ready channels of the triangle vertex transform.
// ----------------------------------------------------------------------------
interface tvt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [1:0]         vertex_slot;
  logic signed [31:0] op_x;
  logic signed [31:0] op_y;
  logic signed [31:0] op_z;
  logic               use_anchor;
  logic signed [31:0] anchor_x;
  logic signed [31:0] anchor_y;
  logic signed [31:0] anchor_z;

  modport source (output valid, operation, vertex_slot, op_x, op_y, op_z,
                  use_anchor, anchor_x, anchor_y, anchor_z, input ready);
  modport sink   (input valid, operation, vertex_slot, op_x, op_y, op_z,
                  use_anchor, anchor_x, anchor_y, anchor_z, output ready);
endinterface

interface tvt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_slot;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] centroid_depth;
  logic               last_vertex;

  modport source (output valid, out_slot, out_x, out_y, out_z, centroid_depth,
                  last_vertex, input ready);
  modport sink   (input valid, out_slot, out_x, out_y, out_z, centroid_depth,
                  last_vertex, output ready);
endinterface

// ===== hdl/tvt_dp.sv =====
// ----------------------------------------------------------------------------
// tvt_dp
// Datapath: vertex store, shared multiplier, constant divider, CORDIC,
// output register.
// ----------------------------------------------------------------------------
module tvt_dp #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tvt_pkg::in_word_t  in_word_i,
  input  tvt_pkg::dp_cmd_t   cmd_i,
  output tvt_pkg::dp_sts_t   sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tvt_pkg::out_word_t out_word_o
);

  localparam int unsigned COR_ITERS = (CORDIC_STEPS < tvt_pkg::TABLE_LEN) ?
                                      CORDIC_STEPS : tvt_pkg::TABLE_LEN;
  localparam int unsigned IT_W = $clog2(COR_ITERS + 1);

  // command latch
  logic [2:0]         op_q;
  logic [1:0]         slot_q;
  logic               anchor_en_q;
  logic signed [31:0] arg_q [3];
  logic signed [31:0] anc_q [3];

  // vertex store [coord][vertex]
  logic signed [31:0] vtx_q [3][3];

  logic signed [31:0] piv_q [3];
  logic signed [31:0] cos_q [3];
  logic signed [31:0] sin_q [3];
  logic signed [31:0] d_q   [3];
  logic signed [31:0] ta_q;
  logic signed [32:0] diff_q;
  logic signed [65:0] prod_q;
  logic signed [65:0] acc_q;
  logic signed [31:0] depth_q;

  // divider
  logic [tvt_pkg::DIV_W-1:0]     num_q, num_d;
  logic [tvt_pkg::DIV_REM_W-1:0] rem_q, rem_d;
  logic [tvt_pkg::DIV_CNT_W-1:0] dcnt_q;
  logic                          dbusy_q;
  logic                          dneg_q;
  tvt_pkg::div_dst_e             ddst_q;
  logic [1:0]                    dk_q;
  logic [14:0]                   dvs_q;
  logic [14:0]                   r_q;
  logic [31:0]                   phase_q;

  // cordic
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [IT_W-1:0]    cit_q;
  logic               cbusy_q;
  logic               cflip_q;
  logic [1:0]         ck_q;

  logic               out_valid_q;
  tvt_pkg::out_word_t out_q;

  logic div_done, cor_done, out_free;

  // --------------------------------------------------------------------------
  // combinational helpers
  logic [1:0]         sk;
  logic signed [33:0] sum;
  logic [33:0]        sum_mag;
  logic signed [31:0] ang;
  logic [31:0]        ang_mag;
  logic [1:0]         t_idx, a_idx, b_idx;
  logic signed [31:0] rc, rs, ra, rb;
  logic signed [32:0] ma, mb;
  logic [31:0]        ph_fold;
  logic               ph_flip;
  logic signed [33:0] xs, ys, stp, cx_d, cy_d, cz_d;
  logic signed [31:0] acc_sat;
  logic signed [31:0] q_signed;
  logic [15:0]        r_wrap;

  always_comb begin
    sk      = (cmd_i.op == tvt_pkg::DP_DEP) ? 2'd2 : cmd_i.ax;
    sum     = 34'(vtx_q[sk][0]) + 34'(vtx_q[sk][1]) + 34'(vtx_q[sk][2]);
    sum_mag = sum[33] ? 34'(-sum) : 34'(sum);
    ang     = arg_q[cmd_i.ax];
    ang_mag = ang[31] ? 32'(-ang) : 32'(ang);
  end

  // rotation stage order z, y, x
  always_comb begin
    unique case (cmd_i.ax)
      2'd0:    begin t_idx = 2'd2; a_idx = 2'd0; b_idx = 2'd1; end
      2'd1:    begin t_idx = 2'd1; a_idx = 2'd2; b_idx = 2'd0; end
      default: begin t_idx = 2'd0; a_idx = 2'd2; b_idx = 2'd1; end
    endcase
    rc = cos_q[t_idx];
    rs = sin_q[t_idx];
    ra = d_q[a_idx];
    rb = d_q[b_idx];
  end

  always_comb begin
    ma = 33'(rc);
    mb = 33'(ra);
    if (cmd_i.op == tvt_pkg::DP_SCL) begin
      ma = 33'(arg_q[cmd_i.ax]);
      mb = diff_q;
    end else begin
      unique case (cmd_i.step)
        3'd1:    begin ma = 33'(rs); mb = 33'(rb); end
        3'd2:    begin ma = 33'(rs); mb = 33'(ra); end
        3'd3:    begin ma = 33'(rc); mb = 33'(rb); end
        default: begin ma = 33'(rc); mb = 33'(ra); end
      endcase
    end
  end

  assign acc_sat = tvt_pkg::sat32(68'(acc_q >>> tvt_pkg::TRIG_BITS));

  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    for (int j = 0; j < tvt_pkg::DIV_DIGITS; j++) begin
      rem_d = {rem_d[tvt_pkg::DIV_REM_W-2:0], num_d[tvt_pkg::DIV_W-1]};
      num_d = {num_d[tvt_pkg::DIV_W-2:0], 1'b0};
      if (rem_d >= 16'(dvs_q)) begin
        rem_d    = rem_d - 16'(dvs_q);
        num_d[0] = 1'b1;
      end
    end
  end

  assign q_signed = dneg_q ? 32'(-num_q[31:0]) : num_q[31:0];
  assign r_wrap   = (dneg_q && rem_q != '0) ? 16'(tvt_pkg::ANGLE_FULL) - rem_q : rem_q;

  assign ph_flip = phase_q[31] ^ phase_q[30];
  assign ph_fold = ph_flip ? phase_q - 32'h8000_0000 : phase_q;

  always_comb begin
    xs  = cx_q >>> cit_q;
    ys  = cy_q >>> cit_q;
    stp = 34'(tvt_pkg::angle_step(5'(cit_q)));
    if (!cz_q[33]) begin
      cx_d = cx_q - ys;
      cy_d = cy_q + xs;
      cz_d = cz_q - stp;
    end else begin
      cx_d = cx_q + ys;
      cy_d = cy_q - xs;
      cz_d = cz_q + stp;
    end
  end

  assign div_done = dbusy_q && (dcnt_q == '0);
  assign cor_done = cbusy_q && (cit_q == IT_W'(COR_ITERS));
  assign out_free = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // vertex store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int v = 0; v < 3; v++) vtx_q[k][v] <= '0;
      end
    end else begin
      unique case (cmd_i.op)
        tvt_pkg::DP_LOAD: begin
          if (slot_q != 2'd3) begin
            for (int k = 0; k < 3; k++) vtx_q[k][slot_q] <= arg_q[k];
          end
        end
        tvt_pkg::DP_TRANS: begin
          for (int k = 0; k < 3; k++) begin
            for (int v = 0; v < 3; v++) begin
              vtx_q[k][v] <= tvt_pkg::sat32(68'(vtx_q[k][v]) + 68'(arg_q[k]));
            end
          end
        end
        tvt_pkg::DP_SCL: begin
          if (cmd_i.step == 3'd2) begin
            vtx_q[cmd_i.ax][cmd_i.vi] <= tvt_pkg::sat32(
                68'(prod_q >>> FRAC_BITS) + 68'(piv_q[cmd_i.ax]));
          end
        end
        tvt_pkg::DP_ROT_POST: begin
          for (int k = 0; k < 3; k++) begin
            vtx_q[k][cmd_i.vi] <= tvt_pkg::sat32(68'(d_q[k]) + 68'(piv_q[k]));
          end
        end
        default: ;
      endcase
    end
  end

  // command latch, pivot, working coordinates, multiplier, accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (cmd_i.op == tvt_pkg::DP_LATCH) begin
      op_q        <= in_word_i.operation;
      slot_q      <= in_word_i.vertex_slot;
      anchor_en_q <= in_word_i.use_anchor;
      arg_q[0]    <= in_word_i.op_x;
      arg_q[1]    <= in_word_i.op_y;
      arg_q[2]    <= in_word_i.op_z;
      anc_q[0]    <= in_word_i.anchor_x;
      anc_q[1]    <= in_word_i.anchor_y;
      anc_q[2]    <= in_word_i.anchor_z;
    end
    if (cmd_i.op == tvt_pkg::DP_PIV_ANCHOR) begin
      for (int k = 0; k < 3; k++) piv_q[k] <= anc_q[k];
    end
    if (div_done && ddst_q == tvt_pkg::DV_CEN) piv_q[dk_q] <= q_signed;
    if (div_done && ddst_q == tvt_pkg::DV_DEP) depth_q <= q_signed;
    if (cmd_i.op == tvt_pkg::DP_SCL && cmd_i.step == 3'd0) begin
      diff_q <= 33'(vtx_q[cmd_i.ax][cmd_i.vi]) - 33'(piv_q[cmd_i.ax]);
    end
    if (cmd_i.op == tvt_pkg::DP_ROT_PRE) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= tvt_pkg::sat32(68'(vtx_q[k][cmd_i.vi]) - 68'(piv_q[k]));
      end
    end
    if (cmd_i.op == tvt_pkg::DP_ROT) begin
      unique case (cmd_i.step)
        3'd1: acc_q <= prod_q;
        3'd2: acc_q <= acc_q - prod_q;
        3'd3: begin
          acc_q <= prod_q;
          ta_q  <= acc_sat;
        end
        3'd4: acc_q <= acc_q + prod_q;
        3'd5: begin
          d_q[a_idx] <= ta_q;
          d_q[b_idx] <= acc_sat;
        end
        default: ;
      endcase
    end
  end

  // constant divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.op == tvt_pkg::DP_CEN || cmd_i.op == tvt_pkg::DP_DEP ||
                 cmd_i.op == tvt_pkg::DP_MOD || cmd_i.op == tvt_pkg::DP_PH) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= tvt_pkg::DIV_CNT_W'(tvt_pkg::DIV_ITERS);
    end else if (div_done) begin
      dbusy_q <= 1'b0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done && ddst_q == tvt_pkg::DV_MOD) r_q <= r_wrap[14:0];
    if (div_done && ddst_q == tvt_pkg::DV_PH) phase_q <= num_q[31:0];
    unique case (cmd_i.op)
      tvt_pkg::DP_CEN, tvt_pkg::DP_DEP: begin
        num_q  <= tvt_pkg::DIV_W'(sum_mag);
        rem_q  <= '0;
        dneg_q <= sum[33];
        dvs_q  <= tvt_pkg::DIV_BY_3;
        dk_q   <= cmd_i.ax;
        ddst_q <= (cmd_i.op == tvt_pkg::DP_DEP) ? tvt_pkg::DV_DEP : tvt_pkg::DV_CEN;
      end
      tvt_pkg::DP_MOD: begin
        num_q  <= tvt_pkg::DIV_W'(ang_mag);
        rem_q  <= '0;
        dneg_q <= ang[31];
        dvs_q  <= tvt_pkg::ANGLE_FULL;
        dk_q   <= cmd_i.ax;
        ddst_q <= tvt_pkg::DV_MOD;
      end
      tvt_pkg::DP_PH: begin
        num_q  <= tvt_pkg::DIV_W'(r_q) << tvt_pkg::PHASE_SHIFT;
        rem_q  <= '0;
        dneg_q <= 1'b0;
        dvs_q  <= tvt_pkg::ANGLE_DIV;
        dk_q   <= cmd_i.ax;
        ddst_q <= tvt_pkg::DV_PH;
      end
      default: begin
        rem_q <= rem_d;
        num_q <= num_d;
      end
    endcase
  end

  // cordic, one iteration per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbusy_q <= 1'b0;
      cit_q   <= '0;
    end else if (cmd_i.op == tvt_pkg::DP_COR) begin
      cbusy_q <= 1'b1;
      cit_q   <= '0;
    end else if (cor_done) begin
      cbusy_q <= 1'b0;
    end else if (cbusy_q) begin
      cit_q <= cit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tvt_pkg::DP_COR) begin
      cx_q    <= tvt_pkg::GAIN_Q30;
      cy_q    <= '0;
      cz_q    <= 34'($signed(ph_fold));
      cflip_q <= ph_flip;
      ck_q    <= cmd_i.ax;
    end else if (cor_done) begin
      cos_q[ck_q] <= cflip_q ? 32'(-cx_q) : 32'(cx_q);
      sin_q[ck_q] <= cflip_q ? 32'(-cy_q) : 32'(cy_q);
    end else if (cbusy_q) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == tvt_pkg::DP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tvt_pkg::DP_EMIT) begin
      out_q.out_slot       <= cmd_i.vi;
      out_q.out_x          <= vtx_q[0][cmd_i.vi];
      out_q.out_y          <= vtx_q[1][cmd_i.vi];
      out_q.out_z          <= vtx_q[2][cmd_i.vi];
      out_q.centroid_depth <= depth_q;
      out_q.last_vertex    <= (cmd_i.vi == 2'd2);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign sts_o.op        = op_q;
  assign sts_o.anchor_en = anchor_en_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.cor_done  = cor_done;
  assign sts_o.out_free  = out_free;

endmodule

// ===== hdl/tvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvt_ctrl
// Command sequencer: steps the datapath through each command.
// ----------------------------------------------------------------------------
module tvt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tvt_pkg::dp_sts_t sts_i,
  output tvt_pkg::dp_cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_CEN     = 5'd2;
  localparam logic [4:0] S_CEN_W   = 5'd3;
  localparam logic [4:0] S_SCL     = 5'd4;
  localparam logic [4:0] S_MOD     = 5'd5;
  localparam logic [4:0] S_MOD_W   = 5'd6;
  localparam logic [4:0] S_PH      = 5'd7;
  localparam logic [4:0] S_PH_W    = 5'd8;
  localparam logic [4:0] S_COR     = 5'd9;
  localparam logic [4:0] S_COR_W   = 5'd10;
  localparam logic [4:0] S_ROT_PRE = 5'd11;
  localparam logic [4:0] S_ROT     = 5'd12;
  localparam logic [4:0] S_ROT_END = 5'd13;
  localparam logic [4:0] S_DEP     = 5'd14;
  localparam logic [4:0] S_DEP_W   = 5'd15;
  localparam logic [4:0] S_EMIT    = 5'd16;

  logic [4:0] state_q, state_d;
  logic [1:0] i_q, i_d;
  logic [1:0] k_q, k_d;
  logic [2:0] st_q, st_d;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    k_d        = k_q;
    st_d       = st_q;
    cmd_o.op   = tvt_pkg::DP_NOP;
    cmd_o.vi   = i_q;
    cmd_o.ax   = k_q;
    cmd_o.step = st_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tvt_pkg::DP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        i_d  = 2'd0;
        k_d  = 2'd0;
        st_d = 3'd0;
        unique case (sts_i.op)
          tvt_pkg::OP_LOAD: begin
            cmd_o.op = tvt_pkg::DP_LOAD;
            state_d  = S_IDLE;
          end
          tvt_pkg::OP_TRANSLATE: begin
            cmd_o.op = tvt_pkg::DP_TRANS;
            state_d  = S_DEP;
          end
          tvt_pkg::OP_SCALE: state_d = S_CEN;
          tvt_pkg::OP_ROTATE: begin
            if (sts_i.anchor_en) begin
              cmd_o.op = tvt_pkg::DP_PIV_ANCHOR;
              state_d  = S_MOD;
            end else begin
              state_d = S_CEN;
            end
          end
          tvt_pkg::OP_READ: state_d = S_DEP;
          default: state_d = S_IDLE;
        endcase
      end
      S_CEN: begin
        cmd_o.op = tvt_pkg::DP_CEN;
        state_d  = S_CEN_W;
      end
      S_CEN_W: begin
        if (sts_i.div_done) begin
          if (k_q == 2'd2) begin
            k_d     = 2'd0;
            state_d = (sts_i.op == tvt_pkg::OP_SCALE) ? S_SCL : S_MOD;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_CEN;
          end
        end
      end
      S_SCL: begin
        cmd_o.op = tvt_pkg::DP_SCL;
        if (st_q == 3'd2) begin
          st_d = 3'd0;
          if (k_q == 2'd2) begin
            k_d = 2'd0;
            if (i_q == 2'd2) state_d = S_DEP;
            else i_d = i_q + 2'd1;
          end else begin
            k_d = k_q + 2'd1;
          end
        end else begin
          st_d = st_q + 3'd1;
        end
      end
      S_MOD: begin
        cmd_o.op = tvt_pkg::DP_MOD;
        state_d  = S_MOD_W;
      end
      S_MOD_W: if (sts_i.div_done) state_d = S_PH;
      S_PH: begin
        cmd_o.op = tvt_pkg::DP_PH;
        state_d  = S_PH_W;
      end
      S_PH_W: if (sts_i.div_done) state_d = S_COR;
      S_COR: begin
        cmd_o.op = tvt_pkg::DP_COR;
        state_d  = S_COR_W;
      end
      S_COR_W: begin
        if (sts_i.cor_done) begin
          if (k_q == 2'd2) begin
            k_d     = 2'd0;
            i_d     = 2'd0;
            st_d    = 3'd0;
            state_d = S_ROT_PRE;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_MOD;
          end
        end
      end
      S_ROT_PRE: begin
        cmd_o.op = tvt_pkg::DP_ROT_PRE;
        k_d      = 2'd0;
        st_d     = 3'd0;
        state_d  = S_ROT;
      end
      S_ROT: begin
        cmd_o.op = tvt_pkg::DP_ROT;
        if (st_q == 3'd5) begin
          st_d = 3'd0;
          if (k_q == 2'd2) state_d = S_ROT_END;
          else k_d = k_q + 2'd1;
        end else begin
          st_d = st_q + 3'd1;
        end
      end
      S_ROT_END: begin
        cmd_o.op = tvt_pkg::DP_ROT_POST;
        if (i_q == 2'd2) begin
          state_d = S_DEP;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = S_ROT_PRE;
        end
      end
      S_DEP: begin
        cmd_o.op = tvt_pkg::DP_DEP;
        state_d  = S_DEP_W;
      end
      S_DEP_W: begin
        if (sts_i.div_done) begin
          i_d     = 2'd0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = tvt_pkg::DP_EMIT;
          if (i_q == 2'd2) state_d = S_IDLE;
          else i_d = i_q + 2'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
      st_q    <= st_d;
    end
  end

endmodule

// ===== hdl/triangle_vertex_transform.sv =====
// ----------------------------------------------------------------------------
// triangle_vertex_transform
// Holds one triangle and loads, translates, scales, rotates or reads it back.
// ----------------------------------------------------------------------------
// One word is taken at a time. A load gives no result; every other command
// gives three words (slots 0, 1, 2, last_vertex on slot 2) carrying the
// vertices and the centroid depth. Translate and read back use the divider
// only for the depth; scale and rotate also wait on the shared constant divider
// at 4 bits per cycle (one division per centroid axis, angle reduction and
// phase), the CORDIC at one iteration per cycle per angle, and the single
// multiplier; a rotation with an anchor skips the centroid. Coordinates are
// signed with FRAC_BITS fraction bits; angles are in 1/64 degree.
// ----------------------------------------------------------------------------
module triangle_vertex_transform #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tvt_in_if.sink    in_i,
  tvt_out_if.source out_o
);

  tvt_pkg::in_word_t  in_word;
  tvt_pkg::out_word_t out_word;
  tvt_pkg::dp_cmd_t   cmd;
  tvt_pkg::dp_sts_t   sts;
  logic               in_ready;
  logic               out_valid;

  assign in_word.operation   = in_i.operation;
  assign in_word.vertex_slot = in_i.vertex_slot;
  assign in_word.op_x        = in_i.op_x;
  assign in_word.op_y        = in_i.op_y;
  assign in_word.op_z        = in_i.op_z;
  assign in_word.use_anchor  = in_i.use_anchor;
  assign in_word.anchor_x    = in_i.anchor_x;
  assign in_word.anchor_y    = in_i.anchor_y;
  assign in_word.anchor_z    = in_i.anchor_z;

  tvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tvt_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid;
  assign out_o.out_slot       = out_word.out_slot;
  assign out_o.out_x          = out_word.out_x;
  assign out_o.out_y          = out_word.out_y;
  assign out_o.out_z          = out_word.out_z;
  assign out_o.centroid_depth = out_word.centroid_depth;
  assign out_o.last_vertex    = out_word.last_vertex;

  a_last_on_slot2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last_vertex == (out_o.out_slot == 2'd2)))
    else $error("last_vertex does not match slot");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.out_slot != 2'd3))
    else $error("out_slot out of range");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a command is in decode");

endmodule
